// ----- design/assert_macros.svh -----
// Assertion helper macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ----- design/bdd_pkg.sv -----
// ----------------------------------------------------------------------------
// bdd_pkg
// Types, codes and the company table of the advertiser dedup table.
// ----------------------------------------------------------------------------
package bdd_pkg;

  localparam logic [1:0] CMD_ADV   = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_SWEEP = 2'd2;

  localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
  localparam logic [1:0] CFG_VWINDOW  = 2'd1;
  localparam logic [1:0] CFG_FWINDOW  = 2'd2;

  localparam logic [15:0] CO_MAIN    = 16'h004C;
  localparam logic [15:0] CO_ALT     = 16'h0006;
  localparam logic [15:0] CO_NONE    = 16'hFFFF;
  localparam logic [7:0]  SUB_NONE   = 8'hFF;
  localparam logic [7:0]  SUB_TV     = 8'h12;

  localparam logic [1:0] CLS_UNKNOWN = 2'd0;
  localparam logic [1:0] CLS_EARBUDS = 2'd1;
  localparam logic [1:0] CLS_TV      = 2'd2;
  localparam logic [1:0] CLS_OTHER   = 2'd3;

  localparam int BRAND_COUNT = 37;
  localparam logic [15:0] BRAND_IDS [BRAND_COUNT] = '{
    16'h004C, 16'h0133, 16'h0075, 16'h000F, 16'h0006, 16'h0059, 16'h00E0, 16'hFFFF,
    16'h007D, 16'h00D2, 16'h00A0, 16'h00C7, 16'h0157, 16'h02E5, 16'h0424, 16'h0171,
    16'h00E3, 16'h00D6, 16'h00E5, 16'h00F0, 16'h01DA, 16'h02E0, 16'h0047, 16'h0048,
    16'h004F, 16'h005A, 16'h0065, 16'h0098, 16'h00A6, 16'h00C8, 16'h00D0, 16'h00E1,
    16'h012D, 16'h0147, 16'h0150, 16'h0160, 16'h01A1
  };

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  mfg_len;
    logic [7:0]  mfg_byte0;
    logic [7:0]  mfg_byte1;
    logic [7:0]  mfg_byte2;
    logic [7:0]  mfg_byte3;
    logic signed [7:0] rssi;
    logic [7:0]  adv_len;
    logic [31:0] name_key;
  } in_item_t;

  typedef struct packed {
    logic [5:0] slot;
    logic       matched;
    logic       inserted;
    logic       dropped;
    logic [1:0] device_class;
    logic [5:0] brand_code;
    logic       want_connect;
    logic [6:0] expired_count;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] company;
    logic [7:0]  subtype;
    logic [7:0]  subtype_set;
    logic signed [7:0] rssi;
    logic [7:0]  adv_len;
    logic [31:0] name_key;
    logic [5:0]  brand;
    logic [1:0]  cls;
  } req_t;

  function automatic logic [5:0] brand_lookup(input logic [15:0] cid);
    logic [5:0] r;
    r = 6'd0;
    for (int k = BRAND_COUNT - 1; k >= 0; k--) begin
      if (BRAND_IDS[k] == cid) r = 6'(k + 1);
    end
    return r;
  endfunction

endpackage

// ----- design/bdd_front.sv -----
// ----------------------------------------------------------------------------
// bdd_front
// Accepts input items and classifies advertisements into requests.
// ----------------------------------------------------------------------------
module bdd_front
  import bdd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     req_valid,
  input  logic     req_stall,
  output req_t     req_data
);

  logic req_valid_r;
  req_t req_data_r;
  req_t req_nxt;
  logic earbuds;
  logic len3;

  assign in_stall = req_valid_r && req_stall;

  always_comb begin
    len3 = (in_data.mfg_len >= 8'd3);
    req_nxt.cmd = in_data.cmd;
    req_nxt.rssi = in_data.rssi;
    req_nxt.adv_len = in_data.adv_len;
    req_nxt.name_key = in_data.name_key;
    req_nxt.company = len3 ? {in_data.mfg_byte1, in_data.mfg_byte0} : CO_NONE;
    req_nxt.subtype = len3 ? in_data.mfg_byte2 : SUB_NONE;
    req_nxt.subtype_set = (len3 && req_nxt.company == CO_MAIN) ? in_data.mfg_byte2 : SUB_NONE;
    req_nxt.brand = (in_data.mfg_len >= 8'd2) ?
                    brand_lookup({in_data.mfg_byte1, in_data.mfg_byte0}) : 6'd0;
    earbuds = 1'b0;
    if (in_data.mfg_len >= 8'd5 && in_data.mfg_byte0 == 8'h4C && in_data.mfg_byte1 == 8'h00)
    begin
      if (in_data.mfg_byte2 == 8'h07 && in_data.mfg_byte3 == 8'h19) earbuds = 1'b1;
      if (in_data.mfg_byte2 == 8'h06 && in_data.mfg_byte3 == 8'h03) earbuds = 1'b1;
      if (in_data.mfg_len >= 8'd25 && in_data.mfg_byte2 == 8'h01) earbuds = 1'b1;
    end
    priority if (earbuds) begin
      req_nxt.cls = CLS_EARBUDS;
    end else if (req_nxt.company == CO_MAIN && req_nxt.subtype_set == SUB_TV) begin
      req_nxt.cls = CLS_TV;
    end else if (req_nxt.company == CO_MAIN) begin
      req_nxt.cls = CLS_OTHER;
    end else begin
      req_nxt.cls = CLS_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (!in_stall) begin
      req_valid_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      req_data_r <= req_nxt;
    end
  end

  assign req_valid = req_valid_r;
  assign req_data  = req_data_r;

endmodule

// ----- design/bdd_queue.sv -----
// ----------------------------------------------------------------------------
// bdd_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bdd_queue
  import bdd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_stall,
  input  req_t wr_data,
  output logic rd_valid,
  input  logic rd_stall,
  output req_t rd_data
);

  req_t       mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rptr_r];
  assign push = wr_valid && !wr_stall;
  assign pop  = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (pop)  rptr_r <= !rptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) mem_r[wptr_r] <= wr_data;
  end

  `ASSERT_NEVER(a_q_over, clk, rst_n, cnt_r == 2'd3, "queue count out of range")
  `ASSERT_CLK(a_q_full, clk, rst_n, (cnt_r == 2'd2 && !pop) |=> cnt_r == 2'd2, "full queue lost entry")
  `ASSERT_CLK(a_q_push, clk, rst_n, (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1, "push not counted")

endmodule

// ----- design/bdd_back.sv -----
// ----------------------------------------------------------------------------
// bdd_back
// Walks the entry table one slot a cycle to match, insert or expire.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bdd_back
  import bdd_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req_data,
  input  logic [31:0] timeout_ticks,
  input  logic [7:0]  vendor_rssi_window,
  input  logic [7:0]  fallback_rssi_window,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  typedef struct packed {
    logic [15:0] company;
    logic [7:0]  subtype;
    logic signed [7:0] rssi;
    logic [7:0]  adv_len;
    logic [31:0] name_key;
    logic [31:0] seen_tick;
  } entry_t;

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_r;
  logic [TABLE_ENTRIES-1:0] valid_r;

  logic [1:0]    state_r;
  req_t          req_r;
  logic [CW-1:0] idx_r;      // slot whose data is in rd_r
  logic          rd_ok_r;
  logic          free_found_r;
  logic [IW-1:0] free_slot_r;
  logic [6:0]    exp_cnt_r;
  logic [31:0]   tick_now_r;
  logic          out_valid_r;
  out_item_t     out_r;
  out_item_t     res_r;
  logic          stage_ok;

  logic [IW-1:0] cur;
  logic [IW-1:0] rd_addr;
  logic          cur_valid;
  logic signed [8:0] diff;
  logic [8:0]    gap;
  logic          same;
  logic          aged;
  logic          last;
  logic          wr_en;
  entry_t        wr_data;
  logic [IW-1:0] wr_addr;

  assign cur = idx_r[IW-1:0];
  assign cur_valid = valid_r[cur];
  assign last = (idx_r == CW'(TABLE_ENTRIES - 1));
  assign rd_addr = (state_r == ST_SCAN && rd_ok_r) ? (last ? '0 : IW'(idx_r + CW'(1))) : cur;
  assign stage_ok = !out_valid_r || !out_stall;
  assign req_stall = (state_r != ST_IDLE);

  always_comb begin
    diff = 9'(rd_r.rssi) - 9'(req_r.rssi);
    gap  = diff[8] ? 9'(-diff) : 9'(diff);
    same = 1'b0;
    if (req_r.company == rd_r.company) begin
      unique case (1'b1)
        req_r.company == CO_MAIN: same = (req_r.subtype_set != SUB_NONE) &&
                                         (req_r.subtype_set == rd_r.subtype);
        req_r.company == CO_ALT:  same = 1'b1;
        default:                  same = (gap < {1'b0, vendor_rssi_window});
      endcase
    end
    if (req_r.name_key != 32'd0 && rd_r.name_key == req_r.name_key) same = 1'b1;
    if (rd_r.adv_len == req_r.adv_len && gap < {1'b0, fallback_rssi_window}) same = 1'b1;
    same = same && cur_valid && rd_ok_r;
    aged = cur_valid && rd_ok_r && ((tick_now_r - rd_r.seen_tick) > timeout_ticks);
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = cur;
    wr_data = rd_r;
    if (state_r == ST_SCAN && req_r.cmd == CMD_ADV && rd_ok_r) begin
      if (same) begin
        wr_en = 1'b1;
        wr_data.rssi = req_r.rssi;
        wr_data.seen_tick = tick_now_r;
        if (rd_r.name_key == 32'd0) wr_data.name_key = req_r.name_key;
      end else if (last && !(free_found_r || !cur_valid)) begin
        wr_en = 1'b0;
      end else if (last) begin
        wr_en = 1'b1;
        wr_addr = free_found_r ? free_slot_r : cur;
        wr_data.company = req_r.company;
        wr_data.subtype = req_r.subtype;
        wr_data.rssi = req_r.rssi;
        wr_data.adv_len = req_r.adv_len;
        wr_data.name_key = req_r.name_key;
        wr_data.seen_tick = tick_now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      tick_now_r  <= 32'd0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      rd_ok_r     <= 1'b0;
    end else begin
      if (state_r == ST_DONE && stage_ok) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          idx_r   <= '0;
          rd_ok_r <= 1'b0;
          if (req_valid) begin
            req_r        <= req_data;
            free_found_r <= 1'b0;
            free_slot_r  <= '0;
            exp_cnt_r    <= 7'd0;
            res_r        <= '0;
            priority case (req_data.cmd)
              CMD_TICK: begin
                tick_now_r <= tick_now_r + 32'd1;
                state_r <= ST_DONE;
              end
              CMD_ADV, CMD_SWEEP: state_r <= ST_SCAN;
              default: state_r <= ST_DONE;
            endcase
          end
        end
        ST_SCAN: begin
          if (!rd_ok_r) begin
            rd_ok_r <= 1'b1;   // first read in flight
          end else if (req_r.cmd == CMD_SWEEP) begin
            if (aged) begin
              valid_r[cur] <= 1'b0;
              exp_cnt_r <= exp_cnt_r + 7'd1;
            end
            if (last) begin
              res_r.expired_count <= exp_cnt_r + 7'(aged);
              state_r <= ST_DONE;
            end else begin
              idx_r <= idx_r + CW'(1);
            end
          end else begin
            if (!cur_valid && !free_found_r) begin
              free_found_r <= 1'b1;
              free_slot_r  <= cur;
            end
            if (same) begin
              res_r.slot <= 6'(cur);
              res_r.matched <= 1'b1;
              res_r.device_class <= req_r.cls;
              res_r.brand_code <= req_r.brand;
              state_r <= ST_DONE;
            end else if (last) begin
              if (free_found_r || !cur_valid) begin
                valid_r[free_found_r ? free_slot_r : cur] <= 1'b1;
                res_r.slot <= 6'(free_found_r ? free_slot_r : cur);
                res_r.inserted <= 1'b1;
                res_r.device_class <= req_r.cls;
                res_r.brand_code <= req_r.brand;
                res_r.want_connect <= (req_r.company != CO_MAIN) && (req_r.company != CO_ALT);
              end else begin
                res_r.dropped <= 1'b1;
              end
              state_r <= ST_DONE;
            end else begin
              idx_r <= idx_r + CW'(1);
            end
          end
        end
        ST_DONE: begin
          if (stage_ok) begin
            out_r <= res_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_CLK(a_one_hit, clk, rst_n, (out_valid_r && !$past(out_valid_r)) |-> $countones({out_r.matched, out_r.inserted, out_r.dropped}) <= 1, "multiple outcome flags")
  `ASSERT_NEVER(a_drop_full, clk, rst_n, state_r == ST_SCAN && req_r.cmd == CMD_ADV && rd_ok_r && last && !same && !free_found_r && !cur_valid && wr_en == 1'b0, "free slot not used")
  `ASSERT_CLK(a_busy_stall, clk, rst_n, (state_r == ST_SCAN) |-> req_stall, "scan accepts request")

endmodule

// ----- design/ble_device_dedup_table.sv -----
// ----------------------------------------------------------------------------
// ble_device_dedup_table
// Advertiser dedup table with ageing.
// ----------------------------------------------------------------------------
// Input requests arrive on in_valid/in_stall/in_data (cmd 0 advertisement,
// 1 tick, 2 expiry sweep). Each request gives exactly one result on
// out_valid/out_stall/out_data. Configuration is written through cfg_valid,
// cfg_ready, cfg_index, cfg_wdata; indexes above 2 are ignored.
// The front registers and classifies a request, a two-entry queue holds it,
// and the back walks the entry memory one slot per cycle through its single
// read port; a hit ends the walk of an advertisement early. One request is
// in the back at a time. Up to three requests wait in front and queue.
// Reset clears the valid bits, the tick counter and all handshake state and
// loads the register defaults; no clearing pass is needed.
// When out_stall is high the result holds; the back finishes the next request
// and waits with it; the queue then fills and in_stall rises.
// ----------------------------------------------------------------------------
module ble_device_dedup_table
  import bdd_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic        f_valid, f_stall, b_valid, b_stall;
  req_t        f_data, b_data;
  logic [31:0] timeout_r;
  logic [7:0]  vwin_r, fwin_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= 32'd5000;
      vwin_r    <= 8'd15;
      fwin_r    <= 8'd10;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TIMEOUT: timeout_r <= cfg_wdata;
        CFG_VWINDOW: vwin_r    <= cfg_wdata[7:0];
        CFG_FWINDOW: fwin_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  bdd_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .req_valid(f_valid), .req_stall(f_stall), .req_data(f_data)
  );

  bdd_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_data),
    .rd_valid(b_valid), .rd_stall(b_stall), .rd_data(b_data)
  );

  bdd_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk, .rst_n, .req_valid(b_valid), .req_stall(b_stall), .req_data(b_data),
    .timeout_ticks(timeout_r), .vendor_rssi_window(vwin_r),
    .fallback_rssi_window(fwin_r), .out_valid, .out_stall, .out_data
  );

endmodule
